>>> src/bspline_curve_point_eval_macros.svh
// ----------------------------------------------------------------------------
// B-spline curve evaluator assertion macros
// Immediate-implication and next-cycle-implication checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_CURVE_POINT_EVAL_MACROS_SVH
`define BSPLINE_CURVE_POINT_EVAL_MACROS_SVH
`ifndef SYNTHESIS
`define BCPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcpe check failed");
`define BCPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcpe check failed");
`else
`define BCPE_ASSERT_NOW(lbl, ante, cons)
`define BCPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants of the B-spline curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int NW = 4;   // last index width
    localparam int PW = 3;   // degree width
    localparam int CW = 32;  // coordinate width
    localparam int AW = 19;  // blend weight (u - t_i), scaled by 2^16
    localparam int QW = 37;  // quotient dividend width

    localparam logic [16:0] U_ONE = 17'h10000;

    localparam logic [NW-1:0] LAST_INDEX_RESET = 4'd8;
    localparam logic [PW-1:0] DEGREE_RESET     = 3'd3;

    localparam logic [3:0] CFG_LAST_INDEX = 4'd0;
    localparam logic [3:0] CFG_DEGREE     = 4'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CLASS,
        S_ENDWAIT,
        S_LDRD,
        S_LDWR,
        S_WRD,
        S_MUL,
        S_SUM,
        S_DIVST,
        S_DIV,
        S_WB,
        S_FRD,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        ST_FIRST,
        ST_LAST,
        ST_SPAN
    } st_sel_t;

    typedef enum logic [1:0] {
        RES_FAULT,
        RES_STORE,
        RES_WORK
    } res_sel_t;

    typedef struct packed {
        logic          capture;
        logic          store_wr;
        logic          prep;
        logic          st_rd;
        st_sel_t       st_sel;
        logic          wk_load;
        logic          wk_rd;
        logic          knot;
        logic          mul;
        logic          sum;
        logic          div_start;
        logic          wk_blend;
        logic          out_load;
        res_sel_t      res_sel;
        logic [PW-1:0] j;
        logic [PW-1:0] r;
    } dp_cmd_t;

    typedef struct packed {
        logic          req_mode;
        logic          fault;
        logic          u_zero;
        logic          u_one;
        logic [PW-1:0] top;
        logic          out_free;
        logic          div_done;
    } dp_status_t;

endpackage

>>> src/bcpe_if.sv
// ----------------------------------------------------------------------------
// bcpe interfaces
// Request, result and configuration channels with valid / ready.
// ----------------------------------------------------------------------------
interface bcpe_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [16:0]        param_u;

    modport source (output valid, mode, point_index, point_x, point_y, param_u,
                    input ready);
    modport sink   (input valid, mode, point_index, point_x, point_y, param_u,
                    output ready);
endinterface

interface bcpe_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic               config_fault;

    modport source (output valid, curve_x, curve_y, config_fault, input ready);
    modport sink   (input valid, curve_x, curve_y, config_fault, output ready);
endinterface

interface bcpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/bcpe_div.sv
// ----------------------------------------------------------------------------
// bcpe_div
// Bit-serial floor division of a signed value by a small positive divisor.
// ----------------------------------------------------------------------------
module bcpe_div
    import bcpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [QW-1:0] dividend,
    input  logic [PW-1:0]        divisor,
    output logic                 done,
    output logic [CW-1:0]        quot
);

    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            fin_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   quo_reg;
    logic [PW-1:0]   rem_reg;
    logic            neg_reg;
    logic [CW-1:0]   q_reg;

    logic [PW:0]     rem_sh;
    logic            take;
    logic [PW-1:0]   rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[QW-1]};
    assign take    = rem_sh >= {1'b0, divisor};
    assign rem_sub = PW'(rem_sh - {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else if (fin_reg)
        begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // negative dividend: floor(x/d) = -((-x + d - 1) / d), and -x + d - 1 = ~x + d
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[QW-1];
            quo_reg <= dividend[QW-1] ? (~dividend + QW'(divisor)) : dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? rem_sub : rem_sh[PW-1:0];
            quo_reg <= {quo_reg[QW-2:0], take};
        end
        if (fin_reg)
        begin
            q_reg <= neg_reg ? (~quo_reg[CW-1:0] + 1'b1) : quo_reg[CW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> src/bcpe_dp.sv
// ----------------------------------------------------------------------------
// bcpe_dp
// Datapath: config registers, point store, de Boor work store, knot math,
// blend multipliers, dividers and the result register.
// ----------------------------------------------------------------------------
module bcpe_dp
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int MAX_DEGREE = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               req_mode,
    input  logic [3:0]         point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic [16:0]        param_u,
    input  logic               cfg_valid,
    input  logic [3:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] curve_x,
    output logic signed [31:0] curve_y,
    output logic               config_fault
);

    localparam int IDXW   = $clog2(MAX_POINTS);
    localparam int WDEPTH = MAX_DEGREE + 1;
    localparam int WIDX   = $clog2(WDEPTH);

    logic [NW-1:0] last_index_reg, last_index_next;
    logic [PW-1:0] degree_reg, degree_next;

    logic [NW-1:0] n_eff;
    logic [PW-1:0] p_eff;
    logic [NW-1:0] segs;
    logic [NW-1:0] s_idx;
    logic          sk;

    logic [16:0]   u_reg;
    logic [19:0]   uu_reg;

    logic [CW-1:0] st_x_mem [MAX_POINTS];
    logic [CW-1:0] st_y_mem [MAX_POINTS];
    logic [CW-1:0] st_x_reg, st_y_reg;
    logic [4:0]    st_addr;

    logic [CW-1:0] wk_x_mem [WDEPTH];
    logic [CW-1:0] wk_y_mem [WDEPTH];
    logic [CW-1:0] lo_x_reg, lo_y_reg, hi_x_reg, hi_y_reg;

    logic [5:0]    i_lo, i_hi;
    logic [NW-1:0] t_lo, t_hi;
    logic [19:0]   a_full;
    logic [AW-1:0] a_reg;
    logic [PW-1:0] d_reg;

    logic signed [52:0] prod_x_reg, prod_y_reg;
    logic signed [52:0] num_x_reg, num_y_reg;
    logic signed [52:0] bias;

    logic          done_x, done_y;
    logic [CW-1:0] q_x, q_y;
    logic [CW-1:0] blend_x, blend_y;
    logic [CW-1:0] wk_x_wdata, wk_y_wdata;

    logic          out_valid_reg;
    logic [CW-1:0] curve_x_reg, curve_y_reg;
    logic          fault_reg;
    logic          out_free;

    function automatic logic [NW-1:0] knot_pos(input logic [5:0] i, input logic [PW-1:0] p,
                                                input logic [NW-1:0] sg);
        logic signed [7:0] v;
        begin
            v = $signed({2'b00, i}) - $signed({5'b00000, p});
            if (v < 0)
                return '0;
            else if (v > $signed({4'b0000, sg}))
                return sg;
            else
                return NW'(v);
        end
    endfunction

    // configuration
    always_comb
    begin
        last_index_next = last_index_reg;
        degree_next     = degree_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LAST_INDEX: last_index_next = cfg_data[NW-1:0];
                CFG_DEGREE:     degree_next     = cfg_data[PW-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg <= LAST_INDEX_RESET;
            degree_reg     <= DEGREE_RESET;
        end
        else
        begin
            last_index_reg <= last_index_next;
            degree_reg     <= degree_next;
        end
    end

    assign n_eff = (int'(last_index_reg) > MAX_POINTS - 1) ? NW'(MAX_POINTS - 1)
                                                           : last_index_reg;
    assign p_eff = (degree_reg == '0) ? PW'(1)
                 : ((int'(degree_reg) > MAX_DEGREE) ? PW'(MAX_DEGREE) : degree_reg);
    assign segs  = n_eff - NW'(p_eff) + 1'b1;
    assign s_idx = uu_reg[19:16];
    assign sk    = (uu_reg[15:0] == '0);

    // item capture and span
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            u_reg <= (param_u > U_ONE) ? U_ONE : param_u;
        if (cmd.prep)
            uu_reg <= 20'(u_reg[15:0]) * 20'(segs);
    end

    // control point store
    always_comb
    begin
        case (cmd.st_sel)
            ST_FIRST: st_addr = '0;
            ST_LAST:  st_addr = {1'b0, n_eff};
            ST_SPAN:  st_addr = {1'b0, s_idx} + {2'b00, cmd.j};
            default:  st_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr && (int'(point_index) < MAX_POINTS))
        begin
            st_x_mem[IDXW'(point_index)] <= point_x;
            st_y_mem[IDXW'(point_index)] <= point_y;
        end
        if (cmd.st_rd)
        begin
            st_x_reg <= st_x_mem[IDXW'(st_addr)];
            st_y_reg <= st_y_mem[IDXW'(st_addr)];
        end
    end

    // de Boor work store: one write port, two read ports
    assign blend_x    = (d_reg == '0) ? lo_x_reg : lo_x_reg + q_x;
    assign blend_y    = (d_reg == '0) ? lo_y_reg : lo_y_reg + q_y;
    assign wk_x_wdata = cmd.wk_load ? st_x_reg : blend_x;
    assign wk_y_wdata = cmd.wk_load ? st_y_reg : blend_y;

    always_ff @(posedge clk)
    begin
        if (cmd.wk_load || cmd.wk_blend)
        begin
            wk_x_mem[WIDX'(cmd.j)] <= wk_x_wdata;
            wk_y_mem[WIDX'(cmd.j)] <= wk_y_wdata;
        end
        if (cmd.wk_rd)
        begin
            lo_x_reg <= wk_x_mem[WIDX'(cmd.j - 1'b1)];
            lo_y_reg <= wk_y_mem[WIDX'(cmd.j - 1'b1)];
            hi_x_reg <= wk_x_mem[WIDX'(cmd.j)];
            hi_y_reg <= wk_y_mem[WIDX'(cmd.j)];
        end
    end

    // knots t_i and t_(i+p-r+1), with i = s + j, in units of 1/segs
    assign i_lo   = {2'b00, s_idx} + {3'b000, cmd.j};
    assign i_hi   = i_lo + {3'b000, p_eff} + 6'd1 - {3'b000, cmd.r};
    assign t_lo   = knot_pos(i_lo, p_eff, segs);
    assign t_hi   = knot_pos(i_hi, p_eff, segs);
    assign a_full = uu_reg - {t_lo, 16'h0000};
    assign bias   = $signed({35'd0, d_reg, 15'd0});

    always_ff @(posedge clk)
    begin
        if (cmd.knot)
        begin
            a_reg <= AW'(a_full);
            d_reg <= PW'(t_hi - t_lo);
        end
        if (cmd.mul)
        begin
            prod_x_reg <= $signed({1'b0, a_reg})
                        * ($signed({hi_x_reg[CW-1], hi_x_reg}) - $signed({lo_x_reg[CW-1], lo_x_reg}));
            prod_y_reg <= $signed({1'b0, a_reg})
                        * ($signed({hi_y_reg[CW-1], hi_y_reg}) - $signed({lo_y_reg[CW-1], lo_y_reg}));
        end
        if (cmd.sum)
        begin
            num_x_reg <= prod_x_reg + bias;
            num_y_reg <= prod_y_reg + bias;
        end
    end

    // (a*(hi-lo) + D*2^15) / (D*2^16), floored: drop 16 bits, then divide by D
    bcpe_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_x_reg[52:16]),
        .divisor  (d_reg),
        .done     (done_x),
        .quot     (q_x)
    );

    bcpe_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (num_y_reg[52:16]),
        .divisor  (d_reg),
        .done     (done_y),
        .quot     (q_y)
    );

    // result register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                RES_FAULT:
                begin
                    curve_x_reg <= '0;
                    curve_y_reg <= '0;
                    fault_reg   <= 1'b1;
                end
                RES_STORE:
                begin
                    curve_x_reg <= st_x_reg;
                    curve_y_reg <= st_y_reg;
                    fault_reg   <= 1'b0;
                end
                default:
                begin
                    curve_x_reg <= hi_x_reg;
                    curve_y_reg <= hi_y_reg;
                    fault_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign curve_x      = curve_x_reg;
    assign curve_y      = curve_y_reg;
    assign config_fault = fault_reg;

    assign status.req_mode = req_mode;
    assign status.fault    = ({1'b0, p_eff} > n_eff);
    assign status.u_zero   = (u_reg == '0);
    assign status.u_one    = (u_reg == U_ONE);
    assign status.top      = p_eff - PW'(sk);
    assign status.out_free = out_free;
    assign status.div_done = done_x && done_y;

endmodule

>>> src/bcpe_ctrl.sv
// ----------------------------------------------------------------------------
// bcpe_ctrl
// Sequencer for point loads and the de Boor recursion.
// ----------------------------------------------------------------------------
`include "bspline_curve_point_eval_macros.svh"

module bcpe_ctrl
    import bcpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t        state_reg, state_next;
    logic [PW-1:0] j_reg, j_next;
    logic [PW-1:0] r_reg, r_next;
    res_sel_t      res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
            r_reg     <= '0;
            res_reg   <= RES_FAULT;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && (status.req_mode == MODE_EVAL))
                    state_next = S_PREP;
            end
            S_PREP:
                state_next = S_CLASS;
            S_CLASS:
            begin
                if (status.fault)
                begin
                    res_next   = RES_FAULT;
                    state_next = S_FIN;
                end
                else if (status.u_zero || status.u_one)
                begin
                    res_next   = RES_STORE;
                    state_next = S_ENDWAIT;
                end
                else
                begin
                    res_next   = RES_WORK;
                    j_next     = '0;
                    state_next = S_LDRD;
                end
            end
            S_ENDWAIT:
                state_next = S_FIN;
            S_LDRD:
                state_next = S_LDWR;
            S_LDWR:
            begin
                if (j_reg == status.top)
                begin
                    if (status.top == '0)
                        state_next = S_FRD;
                    else
                    begin
                        r_next     = PW'(1);
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_LDRD;
                end
            end
            S_WRD:
                state_next = S_MUL;
            S_MUL:
                state_next = S_SUM;
            S_SUM:
                state_next = S_DIVST;
            S_DIVST:
                state_next = S_DIV;
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (j_reg == r_reg)
                begin
                    j_next = status.top;
                    if (r_reg == status.top)
                        state_next = S_FRD;
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_WRD;
                    end
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_WRD;
                end
            end
            S_FRD:
                state_next = S_FIN;
            S_FIN:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.st_sel  = ST_SPAN;
        cmd.res_sel = res_reg;
        cmd.j       = j_reg;
        cmd.r       = r_reg;
        req_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.capture  = req_valid;
                cmd.store_wr = req_valid && (status.req_mode == MODE_LOAD);
            end
            S_PREP:
                cmd.prep = 1'b1;
            S_CLASS:
            begin
                cmd.st_rd  = status.u_zero || status.u_one;
                cmd.st_sel = status.u_zero ? ST_FIRST : ST_LAST;
            end
            S_LDRD:
                cmd.st_rd = 1'b1;
            S_LDWR:
                cmd.wk_load = 1'b1;
            S_WRD:
            begin
                cmd.wk_rd = 1'b1;
                cmd.knot  = 1'b1;
            end
            S_MUL:
                cmd.mul = 1'b1;
            S_SUM:
                cmd.sum = 1'b1;
            S_DIVST:
                cmd.div_start = 1'b1;
            S_WB:
                cmd.wk_blend = 1'b1;
            S_FRD:
                cmd.wk_rd = 1'b1;
            S_FIN:
                cmd.out_load = status.out_free;
            default:
                ;
        endcase
    end

    `BCPE_ASSERT_NOW(a_load_when_free, cmd.out_load, status.out_free)
    `BCPE_ASSERT_NOW(a_blend_bounds, state_reg == S_WRD, (r_reg != '0) && (r_reg <= j_reg) && (j_reg <= status.top))
    `BCPE_ASSERT_NEXT(a_result_ends_item, cmd.out_load, state_reg == S_IDLE)
    `BCPE_ASSERT_NOW(a_wb_after_div, state_reg == S_WB, $past(status.div_done))

endmodule

>>> src/bspline_curve_point_eval.sv
// ----------------------------------------------------------------------------
// bspline_curve_point_eval
// Clamped uniform 2-D B-spline evaluator (de Boor), Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Channels: req carries load transactions (mode 0: point_index, point_x,
// point_y) and evaluate transactions (mode 1: param_u, Q1.16). rsp returns
// one curve point per evaluate transaction; loads return nothing. cfg writes
// last_index (index 0) and degree (index 1); the user must write them only
// while the block is idle, which the block itself does not enforce. A load
// is written to the point store as it is accepted. An evaluate runs degree
// de Boor levels (degree 0 counts as 1; one fewer when u sits on a knot);
// each blend reads two work store entries and the knots, multiplies, adds
// the rounding bias, starts the 37-bit bit-serial dividers that run both
// coordinates in parallel, waits for them and writes back. A fault, u = 0
// and u = 1 skip the recursion; each item is accepted in the idle state.
// One item is worked at a time; req is ready again once the result sits in
// the output register, so a stalled receiver holds only the finished result
// and the next item is taken meanwhile.
// Reset returns last_index to 8 and degree to 3 and empties the output
// register; control points hold nothing until loaded.
// ----------------------------------------------------------------------------
module bspline_curve_point_eval
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int MAX_DEGREE = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    bcpe_req_if.sink   req,
    bcpe_rsp_if.source rsp,
    bcpe_cfg_if.sink   cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    bcpe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bcpe_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_mode     (req.mode),
        .point_index  (req.point_index),
        .point_x      (req.point_x),
        .point_y      (req.point_y),
        .param_u      (req.param_u),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .curve_x      (rsp.curve_x),
        .curve_y      (rsp.curve_y),
        .config_fault (rsp.config_fault)
    );

endmodule
